// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Input item opcodes
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_OPEN = 2'd1;
  localparam logic [1:0] OP_FAIL = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_MSG    = 2'd0;
  localparam logic [1:0] KIND_PONG   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_CLOSED = 2'd3;

  // Frame header fields
  localparam logic [3:0] FRAME_DATA_MAX = 4'h2;
  localparam logic [3:0] FRAME_CLOSE    = 4'h8;
  localparam logic [3:0] FRAME_PING     = 4'h9;
  localparam logic [7:0] PONG_HEADER    = 8'h8a;
  localparam logic [6:0] LEN_EXT16      = 7'd126;
  localparam logic [6:0] LEN_EXT64      = 7'd127;
  localparam logic [2:0] EXT16_LAST     = 3'd1;
  localparam logic [2:0] EXT64_LAST     = 3'd7;
  localparam logic [2:0] MASK_LAST      = 3'd3;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Header parser phase, one-hot
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_MASK    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       message_last;
    logic       pong_last;
  } out_item_t;

  // Up to two results produced by one request, first one goes out first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

endpackage

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker; one request per advance.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  wsd_pkg::in_item_t item,
  output wsd_pkg::res_pair_t res
);
  import wsd_pkg::*;

  logic        link_open, link_open_next;
  phase_t      phase, phase_next;
  logic        final_flag, final_flag_next;
  logic [3:0]  frame_kind, frame_kind_next;
  logic        mask_present, mask_present_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_position, key_position_next;

  logic        length_fin;
  logic        header_fin;
  logic [7:0]  b;
  logic [7:0]  v;
  logic [63:0] rem_dec;
  logic        done;
  logic        is_data;

  assign b       = item.rx_byte;
  assign is_data = (frame_kind <= FRAME_DATA_MAX);

  // Unmask the payload byte and count down the payload
  always_comb begin
    v = b;
    if (mask_present) begin
      v = b ^ mask_key[{~key_position, 3'b000} +: 8];
    end
    rem_dec = remaining_length;
    if (remaining_length != 64'd0) begin
      rem_dec = remaining_length - 64'd1;
    end
    done = (rem_dec == 64'd0);
  end

  // Next state and results
  always_comb begin
    link_open_next        = link_open;
    phase_next            = phase;
    final_flag_next       = final_flag;
    frame_kind_next       = frame_kind;
    mask_present_next     = mask_present;
    remaining_length_next = remaining_length;
    header_count_next     = header_count;
    mask_key_next         = mask_key;
    key_position_next     = key_position;
    length_fin            = 1'b0;
    header_fin            = 1'b0;
    res                   = '0;

    if (go) begin
      case (item.opcode)
        OP_OPEN: begin
          link_open_next        = 1'b1;
          phase_next            = PH_FIRST;
          final_flag_next       = 1'b0;
          frame_kind_next       = 4'd0;
          mask_present_next     = 1'b0;
          remaining_length_next = 64'd0;
          header_count_next     = 3'd0;
          mask_key_next         = 32'd0;
          key_position_next     = 2'd0;
        end
        OP_FAIL: begin
          if (link_open) begin
            res.count          = 2'd1;
            res.first.out_kind = KIND_CLOSED;
            link_open_next     = 1'b0;
            phase_next         = PH_FIRST;
          end
        end
        OP_BYTE: begin
          if (link_open) begin
            case (phase)
              PH_SECOND: begin
                mask_present_next     = b[7];
                header_count_next     = 3'd0;
                mask_key_next         = 32'd0;
                remaining_length_next = 64'd0;
                if (b[6:0] == LEN_EXT16) begin
                  phase_next = PH_EXT16;
                end else if (b[6:0] == LEN_EXT64) begin
                  phase_next = PH_EXT64;
                end else begin
                  remaining_length_next = {57'd0, b[6:0]};
                  length_fin            = 1'b1;
                end
              end
              PH_EXT16, PH_EXT64: begin
                remaining_length_next = {remaining_length[55:0], b};
                if (header_count >= ((phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
                  length_fin = 1'b1;
                end else begin
                  header_count_next = header_count + 3'd1;
                end
              end
              PH_MASK: begin
                mask_key_next = {mask_key[23:0], b};
                if (header_count >= MASK_LAST) begin
                  header_fin = 1'b1;
                end else begin
                  header_count_next = header_count + 3'd1;
                end
              end
              PH_PAYLOAD: begin
                key_position_next     = key_position + 2'd1;
                remaining_length_next = rem_dec;
                if (is_data) begin
                  res.count              = 2'd1;
                  res.first.out_kind     = KIND_MSG;
                  res.first.out_byte     = v;
                  res.first.message_last = final_flag & done;
                end else if (frame_kind == FRAME_PING) begin
                  res.count           = 2'd1;
                  res.first.out_kind  = KIND_PONG;
                  res.first.out_byte  = v;
                  res.first.pong_last = done;
                end
                if (done) begin
                  phase_next = PH_FIRST;
                end
              end
              default: begin
                final_flag_next = b[7];
                frame_kind_next = b[3:0];
                phase_next      = PH_SECOND;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // Length complete: fetch the mask key or finish the header
    if (length_fin) begin
      header_count_next = 3'd0;
      if (mask_present_next) begin
        phase_next = PH_MASK;
      end else begin
        header_fin = 1'b1;
      end
    end

    // Header complete: act on the frame kind
    if (header_fin) begin
      key_position_next = 2'd0;
      header_count_next = 3'd0;
      if (frame_kind == FRAME_CLOSE) begin
        res.count          = 2'd1;
        res.first.out_kind = KIND_CLOSED;
        link_open_next     = 1'b0;
        phase_next         = PH_FIRST;
      end else begin
        if (frame_kind == FRAME_PING) begin
          res.count            = 2'd2;
          res.first.out_kind   = KIND_PONG;
          res.first.out_byte   = PONG_HEADER;
          res.second.out_kind  = KIND_PONG;
          res.second.out_byte  = {1'b0, remaining_length_next[6:0]};
          res.second.pong_last = (remaining_length_next == 64'd0);
        end else if ((remaining_length_next == 64'd0) && is_data && final_flag) begin
          res.count              = 2'd1;
          res.first.out_kind     = KIND_END;
          res.first.message_last = 1'b1;
        end
        phase_next = (remaining_length_next == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      end
    end
  end

  // Hold parser state between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      link_open        <= 1'b0;
      phase            <= PH_FIRST;
      final_flag       <= 1'b0;
      frame_kind       <= 4'd0;
      mask_present     <= 1'b0;
      remaining_length <= 64'd0;
      header_count     <= 3'd0;
      mask_key         <= 32'd0;
      key_position     <= 2'd0;
    end else begin
      link_open        <= link_open_next;
      phase            <= phase_next;
      final_flag       <= final_flag_next;
      frame_kind       <= frame_kind_next;
      mask_present     <= mask_present_next;
      remaining_length <= remaining_length_next;
      header_count     <= header_count_next;
      mask_key         <= mask_key_next;
      key_position     <= key_position_next;
    end
  end

endmodule

// ===== rtl/wsd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// wsd_out_fifo
// Small result queue taking up to two results and giving one per cycle on pop.
// ----------------------------------------------------------------------------
module wsd_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  wsd_pkg::res_pair_t             push,
  input  logic                           pop,
  output logic [wsd_pkg::QCNT_W-1:0]     count,
  output wsd_pkg::out_item_t             head
);
  import wsd_pkg::*;

  out_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count_next;

  assign head       = mem[rd_ptr];
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  // Write one or two entries
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with payload unmasking and ping echo.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_stall    in_item_t  (opcode, rx_byte)
//   result   out        result_valid / result_stall out_item_t (kind, byte, lasts)
//
// One request is taken per cycle while item_stall is low. It is parsed from
// the input register when the queue has room; its results can be taken
// from the next cycle on. A ping header gives two results, so the rate then
// drops to the output rate. The input register holds while the four-entry
// result queue has room for fewer than two results. Reset is synchronous
// and clears parser state and the queue; the link starts closed.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  wsd_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output wsd_pkg::out_item_t result
);
  import wsd_pkg::*;

  in_item_t          in_q;
  logic              in_q_valid;
  logic              advance;
  logic              pop;
  logic [QCNT_W-1:0] count;
  res_pair_t         res;

  // Parse the held request when the queue can take two results
  assign advance    = in_q_valid && (count <= QCNT_W'(QDEPTH - 2));
  assign item_stall = in_q_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  wsd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (in_q),
    .res  (res)
  );

  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;

  wsd_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res),
    .pop   (pop),
    .count (count),
    .head  (result)
  );

  // Queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // Results only come from a parsed request
  a_res_needs_go: assert property (@(posedge clk) disable iff (rst)
    (res.count != 2'd0) |-> advance)
    else $error("result without parsed request");

  // Two results only for a pong header
  a_pair_is_pong: assert property (@(posedge clk) disable iff (rst)
    (res.count == 2'd2) |-> (res.first.out_kind == KIND_PONG &&
                             res.first.out_byte == PONG_HEADER))
    else $error("result pair is not a pong header");

  // Stall only when the queue lacks room
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (count > QCNT_W'(QDEPTH - 2)))
    else $error("input stalled with queue room");

endmodule
